FILE: hdl/cau_pkg.sv
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int PW = 2 * DATA_WIDTH;
   localparam int MW = 2 * DATA_WIDTH + 1;
   localparam int SW = 2 * DATA_WIDTH + 2;
   localparam int NW = MW + FRAC_BITS;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]                   command;
      logic signed [DATA_WIDTH-1:0] a_re;
      logic signed [DATA_WIDTH-1:0] a_im;
      logic signed [DATA_WIDTH-1:0] b_re;
      logic signed [DATA_WIDTH-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] res_re;
      logic signed [DATA_WIDTH-1:0] res_im;
      logic [1:0]                   status;
   } rsp_type;

   typedef struct packed {
      logic                  neg;
      logic [MW-1:0]         mag;
      logic [MW-1:0]         r;
      logic [DATA_WIDTH-1:0] lo;
      logic [DATA_WIDTH-1:0] q;
      logic                  ovf;
   } lane_type;

   typedef struct packed {
      logic          vld;
      cmd_type       cmd;
      logic [MW-1:0] den;
      lane_type      re;
      lane_type      im;
   } beat_type;

endpackage

FILE: hdl/cau_front.sv
module cau_front
   import cau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_vld,
   input  req_type  in_req,
   output beat_type out_beat
);

   function automatic logic [SW-1:0] sx(input logic neg, input logic [PW-1:0] mag);
      logic [SW-1:0] v;
      v = {2'b00, mag};
      return neg ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [SW-1:0] dx(input logic [DATA_WIDTH-1:0] v);
      return {{(SW-DATA_WIDTH){v[DATA_WIDTH-1]}}, v};
   endfunction

   function automatic logic [DATA_WIDTH-1:0] mg(input logic [DATA_WIDTH-1:0] v);
      return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic lane_type mk(input logic [SW-1:0] s, input logic [MW-1:0] den);
      lane_type l;
      logic [NW-1:0] n;
      logic [NW-DATA_WIDTH-1:0] top;
      l.neg = s[SW-1];
      l.mag = s[SW-1] ? MW'(~s + 1'b1) : s[MW-1:0];
      n = {l.mag, {FRAC_BITS{1'b0}}};
      top = n[NW-1:DATA_WIDTH];
      l.ovf = MW'(top) >= den;
      l.r = MW'(top);
      l.lo = n[DATA_WIDTH-1:0];
      l.q = '0;
      return l;
   endfunction

   logic    s1_vld_ff, s2_vld_ff;
   req_type s1_req_ff;
   logic    s1_nar_ff, s1_nai_ff, s1_nbr_ff, s1_nbi_ff;
   logic [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic [DATA_WIDTH-1:0] m_ar, m_ai, m_br, m_bi;

   cmd_type       s2_cmd_ff;
   logic [SW-1:0] s2_re_ff, s2_im_ff;
   logic [MW-1:0] s2_den_ff;
   logic [SW-1:0] re_in, im_in;
   beat_type      s3_ff;

   assign m_ar = mg(in_req.a_re);
   assign m_ai = mg(in_req.a_im);
   assign m_br = mg(in_req.b_re);
   assign m_bi = mg(in_req.b_im);

   always_comb begin
      case (cmd_type'(s1_req_ff.command))
         CMD_ADD: begin
            re_in = dx(s1_req_ff.a_re) + dx(s1_req_ff.b_re);
            im_in = dx(s1_req_ff.a_im) + dx(s1_req_ff.b_im);
         end
         CMD_SUB: begin
            re_in = dx(s1_req_ff.a_re) - dx(s1_req_ff.b_re);
            im_in = dx(s1_req_ff.a_im) - dx(s1_req_ff.b_im);
         end
         CMD_MUL: begin
            re_in = sx(s1_nar_ff ^ s1_nbr_ff, p_rr_ff) - sx(s1_nai_ff ^ s1_nbi_ff, p_ii_ff);
            im_in = sx(s1_nar_ff ^ s1_nbi_ff, p_ri_ff) + sx(s1_nbr_ff ^ s1_nai_ff, p_ir_ff);
         end
         default: begin
            re_in = sx(s1_nar_ff ^ s1_nbr_ff, p_rr_ff) + sx(s1_nai_ff ^ s1_nbi_ff, p_ii_ff);
            im_in = sx(s1_nbr_ff ^ s1_nai_ff, p_ir_ff) - sx(s1_nar_ff ^ s1_nbi_ff, p_ri_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_ff.vld <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_ff.vld <= s2_vld_ff;
      end
      if (en) begin
         s1_req_ff <= in_req;
         s1_nar_ff <= in_req.a_re[DATA_WIDTH-1];
         s1_nai_ff <= in_req.a_im[DATA_WIDTH-1];
         s1_nbr_ff <= in_req.b_re[DATA_WIDTH-1];
         s1_nbi_ff <= in_req.b_im[DATA_WIDTH-1];
         p_rr_ff   <= PW'(m_ar) * PW'(m_br);
         p_ii_ff   <= PW'(m_ai) * PW'(m_bi);
         p_ri_ff   <= PW'(m_ar) * PW'(m_bi);
         p_ir_ff   <= PW'(m_br) * PW'(m_ai);
         p_bb_ff   <= PW'(m_br) * PW'(m_br);
         p_cc_ff   <= PW'(m_bi) * PW'(m_bi);
         s2_cmd_ff <= cmd_type'(s1_req_ff.command);
         s2_re_ff  <= re_in;
         s2_im_ff  <= im_in;
         s2_den_ff <= MW'(p_bb_ff) + MW'(p_cc_ff);
         s3_ff.cmd <= s2_cmd_ff;
         s3_ff.den <= s2_den_ff;
         s3_ff.re  <= mk(s2_re_ff, s2_den_ff);
         s3_ff.im  <= mk(s2_im_ff, s2_den_ff);
      end
   end

   assign out_beat = s3_ff;

endmodule

FILE: hdl/cau_div_cell.sv
module cau_div_cell
   import cau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  beat_type in_beat,
   output beat_type out_beat
);

   function automatic lane_type step(input lane_type l, input logic [MW-1:0] den);
      lane_type o;
      logic [MW-1:0] r2;
      o = l;
      r2 = {l.r[MW-2:0], l.lo[DATA_WIDTH-1]};
      o.lo = {l.lo[DATA_WIDTH-2:0], 1'b0};
      if (r2 >= den) begin
         o.r = r2 - den;
         o.q = {l.q[DATA_WIDTH-2:0], 1'b1};
      end else begin
         o.r = r2;
         o.q = {l.q[DATA_WIDTH-2:0], 1'b0};
      end
      return o;
   endfunction

   beat_type beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.vld <= 1'b0;
      end else if (en) begin
         beat_ff.vld <= in_beat.vld;
      end
      if (en) begin
         beat_ff.cmd <= in_beat.cmd;
         beat_ff.den <= in_beat.den;
         beat_ff.re  <= step(in_beat.re, in_beat.den);
         beat_ff.im  <= step(in_beat.im, in_beat.den);
      end
   end

   assign out_beat = beat_ff;

endmodule

FILE: hdl/complex_arithmetic_unit.sv
// complex_arithmetic_unit: add, subtract, multiply or divide of two complex Q8.8 numbers
//
// req channel: one beat per operation (command, a_re, a_im, b_re, b_im), valid/ready.
// rsp channel: one beat per request, in order (res_re, res_im, status), valid/ready.
// status is 0 ok, 1 when a part saturated, 2 on divide by zero (result zero).
//
// a request runs from accept to response valid through three front stages
// (products, sums, divide setup), one cell per quotient bit (16 cells), and the
// output register. every operation runs through the whole chain, so throughput is
// one beat per cycle regardless of the command mix, unless the output stalls.
//
// the whole pipeline advances together; when rsp_ready is low with a response
// waiting, every stage holds and req_ready drops. an empty output slot lets the
// pipeline move even while the receiver stalls.
// reset clears all valid bits; nothing else is initialized.
module complex_arithmetic_unit
   import cau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [MW-1:0] POS_MAX = MW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
   localparam logic [MW-1:0] NEG_MAX = MW'(64'd1 << (DATA_WIDTH - 1));

   logic     en;
   beat_type chain [DATA_WIDTH+1];
   beat_type last;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;
   logic     clip_re, clip_im;
   logic [DATA_WIDTH-1:0] v_re, v_im;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_valid),
      .in_req   (req_data),
      .out_beat (chain[0])
   );

   for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
      cau_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_beat  (chain[k]),
         .out_beat (chain[k+1])
      );
   end

   assign last = chain[DATA_WIDTH];

   function automatic logic [DATA_WIDTH:0] fin(input lane_type l, input cmd_type c);
      logic [MW-1:0] m;
      logic          big;
      logic          n;
      big = 1'b0;
      case (c)
         CMD_MUL: m = l.mag >> FRAC_BITS;
         CMD_DIV: begin
            m   = MW'(l.q);
            big = l.ovf;
         end
         default: m = l.mag;
      endcase
      n = l.neg && (m != '0 || big);
      if (!n && (big || m > POS_MAX)) begin
         return {1'b1, POS_MAX[DATA_WIDTH-1:0]};
      end else if (n && (big || m > NEG_MAX)) begin
         return {1'b1, NEG_MAX[DATA_WIDTH-1:0]};
      end else if (n) begin
         return {1'b0, DATA_WIDTH'(~m + 1'b1)};
      end
      return {1'b0, m[DATA_WIDTH-1:0]};
   endfunction

   assign {clip_re, v_re} = fin(last.re, last.cmd);
   assign {clip_im, v_im} = fin(last.im, last.cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= last.vld;
      end
      if (en) begin
         if (last.cmd == CMD_DIV && last.den == '0) begin
            rsp_ff.res_re <= '0;
            rsp_ff.res_im <= '0;
            rsp_ff.status <= ST_DIV0;
         end else begin
            rsp_ff.res_re <= v_re;
            rsp_ff.res_im <= v_im;
            rsp_ff.status <= (clip_re || clip_im) ? ST_SAT : ST_OK;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
